// File: hw/rtl/wvsm_pkg.sv
`default_nettype none

package wvsm_pkg;

  // Request kinds carried on s_tuser
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_COUNT = 2'd1,
    REQ_TICK  = 2'd2
  } req_type_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOW_MUL,
    ST_DOW_SUM,
    ST_DOW_MOD,
    ST_DOW_FIX,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } wvsm_state_e;

  // Valve modes, two bits per valve
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_SCHED = 2'd2;

  // Configuration register indexes
  localparam logic CFG_POLARITY = 1'b0;
  localparam logic CFG_MODES    = 1'b1;

  localparam int CFG_W     = 32;
  localparam int PATTERN_W = 16;
  localparam int DOW_W     = 3;

  // Input tdata layout, lowest bit first
  localparam int IN_TDATA_W = 56;
  localparam int OFF_VALVE  = 0;
  localparam int OFF_SLOT   = 4;
  localparam int OFF_WDAY   = 8;
  localparam int OFF_HA     = 11;
  localparam int OFF_MA     = 16;
  localparam int OFF_HB     = 22;
  localparam int OFF_MB     = 27;
  localparam int OFF_DDAY   = 33;
  localparam int OFF_MONTH  = 38;
  localparam int OFF_YEAR   = 42;

  localparam int VALVE_W = 4;
  localparam int SLOT_W  = 4;
  localparam int WDAY_W  = 3;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int DDAY_W  = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 12;

  // Output tdata layout
  localparam int OUT_TDATA_W = 24;

  // Window entry layout: day, start hour, start minute, stop hour, stop minute
  localparam int WIN_W      = 25;
  localparam int WOFF_EM    = 0;
  localparam int WOFF_EH    = 6;
  localparam int WOFF_SM    = 11;
  localparam int WOFF_SH    = 17;
  localparam int WOFF_DAY   = 22;

  // Range limits for window writes
  localparam logic [WDAY_W-1:0] MAX_WDAY = 3'd6;
  localparam logic [HOUR_W-1:0] MAX_HOUR = 5'd23;
  localparam logic [MIN_W-1:0]  MAX_MIN  = 6'd59;

  // Day-of-week arithmetic
  localparam int SUM_W  = 13;
  localparam logic [12:0] RECIP_100 = 13'd5243;  // 2^19 / 100, rounded up
  localparam int SHIFT_100 = 19;
  localparam logic [13:0] RECIP_7   = 14'd9363;  // 2^16 / 7, rounded up
  localparam int SHIFT_7   = 16;
  localparam logic [SUM_W-1:0] DOW_BIAS = 13'd4;
  localparam logic [MONTH_W-1:0] MARCH  = 4'd3;

  // 23 * m / 9 for every month code
  localparam logic [5:0] MONTH_TERM [16] = '{
    6'd0,  6'd2,  6'd5,  6'd7,  6'd10, 6'd12, 6'd15, 6'd17,
    6'd20, 6'd23, 6'd25, 6'd28, 6'd30, 6'd33, 6'd35, 6'd38
  };

  // Controller to datapath
  typedef struct packed {
    logic cap_tick;
    logic wr_win;
    logic wr_cnt;
    logic ld_mul;
    logic ld_sum;
    logic ld_mod;
    logic ld_dow;
    logic scan_start;
    logic scan_step;
    logic ld_out;
  } wvsm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
  } wvsm_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/weekly_valve_schedule_matcher_core.sv
`default_nettype none

// Weekly time-window scheduler for up to VALVE_COUNT valves with up to
// MAX_WINDOWS windows each. Window writes and count writes are accepted
// back to back. A tick first finds the day of week in the states DOW_MUL,
// DOW_SUM, DOW_MOD and DOW_FIX (a 1/100 reciprocal multiply, a sum, a 1/7
// reciprocal multiply and a correction), then scans, stepping once per used
// window of every scheduled valve with a nonzero count and once for each
// other valve, as the scan reads the two-port window memory once per
// cycle, then drains the last read and loads the result once the output
// register is free or being read. The next request is taken in the cycle
// after the result is loaded, while the result still waits in its output
// register. No clearing pass is needed after reset; a slot counted as used
// must have been written.

module weekly_valve_schedule_matcher_core #(
  parameter int VALVE_COUNT = 16,
  parameter int MAX_WINDOWS = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // request stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // valve_index, slot_index, week_day, hour_a, minute_a, hour_b, minute_b,
  // date_day, date_month, date_year, zero fill
  input  wire logic [wvsm_pkg::IN_TDATA_W-1:0]    s_tdata,
  // req_type
  input  wire logic [1:0]                         s_tuser,
  // result stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // valve_pattern, day_of_week_out, zero fill
  output logic [wvsm_pkg::OUT_TDATA_W-1:0]        m_tdata,
  // configuration writes
  input  wire logic                               cfg_we_i,
  input  wire logic                               cfg_index_i,
  input  wire logic [wvsm_pkg::CFG_W-1:0]         cfg_wdata_i
);

  wvsm_pkg::wvsm_cmd_t    cmd;
  wvsm_pkg::wvsm_status_t status;

  wvsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .req_type_i (s_tuser),
    .m_tready_i (m_tready),
    .m_tvalid_o (m_tvalid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wvsm_datapath #(
    .VALVE_COUNT (VALVE_COUNT),
    .MAX_WINDOWS (MAX_WINDOWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .s_tdata_i   (s_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_tdata_o   (m_tdata)
  );

endmodule

`default_nettype wire

// File: hw/rtl/wvsm_ctrl.sv
`default_nettype none

module wvsm_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  input  wire logic [1:0]            req_type_i,
  input  wire logic                  m_tready_i,
  output logic                       m_tvalid_o,
  input  wire wvsm_pkg::wvsm_status_t status_i,
  output wvsm_pkg::wvsm_cmd_t        cmd_o
);

  wvsm_pkg::wvsm_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  // State and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wvsm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_tready_o = (state_q == wvsm_pkg::ST_IDLE);
  assign m_tvalid_o = out_valid_q;
  assign accept     = s_tvalid_i && s_tready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      wvsm_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_type_i == wvsm_pkg::REQ_WRITE) begin
            cmd_o.wr_win = 1'b1;
          end else if (req_type_i == wvsm_pkg::REQ_COUNT) begin
            cmd_o.wr_cnt = 1'b1;
          end else if (req_type_i == wvsm_pkg::REQ_TICK) begin
            cmd_o.cap_tick = 1'b1;
            state_d        = wvsm_pkg::ST_DOW_MUL;
          end
        end
      end
      wvsm_pkg::ST_DOW_MUL: begin
        cmd_o.ld_mul = 1'b1;
        state_d      = wvsm_pkg::ST_DOW_SUM;
      end
      wvsm_pkg::ST_DOW_SUM: begin
        cmd_o.ld_sum = 1'b1;
        state_d      = wvsm_pkg::ST_DOW_MOD;
      end
      wvsm_pkg::ST_DOW_MOD: begin
        cmd_o.ld_mod = 1'b1;
        state_d      = wvsm_pkg::ST_DOW_FIX;
      end
      wvsm_pkg::ST_DOW_FIX: begin
        cmd_o.ld_dow     = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = wvsm_pkg::ST_SCAN;
      end
      wvsm_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = wvsm_pkg::ST_DRAIN;
        end
      end
      wvsm_pkg::ST_DRAIN: begin
        // last read result folds into the hit vector
        state_d = wvsm_pkg::ST_FINISH;
      end
      wvsm_pkg::ST_FINISH: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.ld_out = 1'b1;
          state_d      = wvsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wvsm_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.ld_out) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/wvsm_datapath.sv
`default_nettype none

module wvsm_datapath #(
  parameter int VALVE_COUNT = 16,
  parameter int MAX_WINDOWS = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire wvsm_pkg::wvsm_cmd_t                 cmd_i,
  output wvsm_pkg::wvsm_status_t                   status_o,
  input  wire logic [wvsm_pkg::IN_TDATA_W-1:0]     s_tdata_i,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_index_i,
  input  wire logic [wvsm_pkg::CFG_W-1:0]          cfg_wdata_i,
  output logic [wvsm_pkg::OUT_TDATA_W-1:0]         m_tdata_o
);

  localparam int DEPTH = VALVE_COUNT * MAX_WINDOWS;
  localparam int VIW   = (VALVE_COUNT > 1) ? $clog2(VALVE_COUNT) : 1;
  localparam int KW    = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CW    = $clog2(MAX_WINDOWS + 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = AW + 4;

  // Input fields
  logic [wvsm_pkg::VALVE_W-1:0] in_valve;
  logic [wvsm_pkg::SLOT_W-1:0]  in_slot;
  logic [wvsm_pkg::WDAY_W-1:0]  in_wday;
  logic [wvsm_pkg::HOUR_W-1:0]  in_ha, in_hb;
  logic [wvsm_pkg::MIN_W-1:0]   in_ma, in_mb;

  assign in_valve = s_tdata_i[wvsm_pkg::OFF_VALVE +: wvsm_pkg::VALVE_W];
  assign in_slot  = s_tdata_i[wvsm_pkg::OFF_SLOT  +: wvsm_pkg::SLOT_W];
  assign in_wday  = s_tdata_i[wvsm_pkg::OFF_WDAY  +: wvsm_pkg::WDAY_W];
  assign in_ha    = s_tdata_i[wvsm_pkg::OFF_HA    +: wvsm_pkg::HOUR_W];
  assign in_ma    = s_tdata_i[wvsm_pkg::OFF_MA    +: wvsm_pkg::MIN_W];
  assign in_hb    = s_tdata_i[wvsm_pkg::OFF_HB    +: wvsm_pkg::HOUR_W];
  assign in_mb    = s_tdata_i[wvsm_pkg::OFF_MB    +: wvsm_pkg::MIN_W];

  // Configuration registers
  logic [wvsm_pkg::PATTERN_W-1:0] pol_q;
  logic [wvsm_pkg::CFG_W-1:0]     modes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q   <= '1;
      modes_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == wvsm_pkg::CFG_POLARITY) begin
        pol_q <= cfg_wdata_i[wvsm_pkg::PATTERN_W-1:0];
      end else begin
        modes_q <= cfg_wdata_i;
      end
    end
  end

  // Write and count request checks
  logic valve_ok, slot_ok, count_ok, win_ok;
  logic [LW-1:0] wr_lin;
  logic [AW-1:0] wr_addr;

  assign valve_ok = {1'b0, in_valve} < 5'(VALVE_COUNT);
  assign slot_ok  = {4'b0, in_slot} < 8'(MAX_WINDOWS);
  assign count_ok = {4'b0, in_slot} <= 8'(MAX_WINDOWS);
  assign win_ok   = valve_ok && slot_ok && (in_wday <= wvsm_pkg::MAX_WDAY) &&
                    (in_ha <= wvsm_pkg::MAX_HOUR) && (in_ma <= wvsm_pkg::MAX_MIN) &&
                    (in_hb <= wvsm_pkg::MAX_HOUR) && (in_mb <= wvsm_pkg::MAX_MIN);
  assign wr_lin   = LW'(in_valve) * LW'(MAX_WINDOWS) + LW'(in_slot);
  assign wr_addr  = wr_lin[AW-1:0];

  // Window counts, one per valve
  logic [CW-1:0] cnt_q [VALVE_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VALVE_COUNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.wr_cnt && valve_ok && count_ok) begin
      cnt_q[in_valve[VIW-1:0]] <= CW'(in_slot);
    end
  end

  // Tick capture
  logic [wvsm_pkg::HOUR_W-1:0]  hr_q;
  logic [wvsm_pkg::MIN_W-1:0]   mn_q;
  logic [wvsm_pkg::DDAY_W-1:0]  dday_q;
  logic [wvsm_pkg::MONTH_W-1:0] mon_q;
  logic [wvsm_pkg::YEAR_W-1:0]  year_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_tick) begin
      hr_q   <= in_ha;
      mn_q   <= in_ma;
      dday_q <= s_tdata_i[wvsm_pkg::OFF_DDAY  +: wvsm_pkg::DDAY_W];
      mon_q  <= s_tdata_i[wvsm_pkg::OFF_MONTH +: wvsm_pkg::MONTH_W];
      year_q <= s_tdata_i[wvsm_pkg::OFF_YEAR  +: wvsm_pkg::YEAR_W];
    end
  end

  // Day of week: year for the quotient terms, times 1/100
  logic                         early_month;
  logic [wvsm_pkg::YEAR_W-1:0]  ysel, ysel_q;
  logic [24:0]                  prod_q;

  assign early_month = mon_q < wvsm_pkg::MARCH;

  always_comb begin
    ysel = year_q;
    if (early_month) begin
      // year zero steps back to -1, whose quotients all truncate to zero
      ysel = (year_q == '0) ? '0 : year_q - 12'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_mul) begin
      ysel_q <= ysel;
      prod_q <= 25'(ysel) * 25'(wvsm_pkg::RECIP_100);
    end
  end

  // Sum of all terms, always non-negative
  logic [5:0]                  q100;
  logic [3:0]                  q400;
  logic [9:0]                  q4;
  logic [wvsm_pkg::SUM_W-1:0]  sum_d, sum_q;

  assign q100 = prod_q[wvsm_pkg::SHIFT_100 +: 6];
  assign q400 = q100[5:2];
  assign q4   = ysel_q[wvsm_pkg::YEAR_W-1:2];

  always_comb begin
    sum_d = 13'(wvsm_pkg::MONTH_TERM[mon_q]) + 13'(dday_q) + wvsm_pkg::DOW_BIAS +
            13'(year_q) + 13'(q4) - 13'(q100) + 13'(q400);
    if (!early_month) begin
      sum_d = sum_d - 13'd2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_sum) begin
      sum_q <= sum_d;
    end
  end

  // Remainder by 7 through the reciprocal
  logic [26:0]                 mprod_q;
  logic [10:0]                 q7;
  logic [wvsm_pkg::SUM_W-1:0]  rem;
  logic [wvsm_pkg::DOW_W-1:0]  dow_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_mod) begin
      mprod_q <= 27'(sum_q) * 27'(wvsm_pkg::RECIP_7);
    end
  end

  assign q7  = mprod_q[wvsm_pkg::SHIFT_7 +: 11];
  assign rem = sum_q - 13'(q7) * 13'd7;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_dow) begin
      dow_q <= rem[wvsm_pkg::DOW_W-1:0];
    end
  end

  // Scan counters over valves and their used slots
  logic [VIW-1:0] vi_q, vi_d;
  logic [KW-1:0]  k_q, k_d;
  logic [1:0]     cur_mode;
  logic [CW-1:0]  cur_cnt;
  logic           active, next_valve, rd_en;
  logic [LW-1:0]  rd_lin;
  logic [AW-1:0]  rd_addr;

  assign cur_mode = modes_q[{vi_q, 1'b0} +: 2];
  assign cur_cnt  = cnt_q[vi_q];
  assign active   = (cur_mode == wvsm_pkg::MODE_SCHED) && (cur_cnt != '0);
  assign rd_lin   = LW'(vi_q) * LW'(MAX_WINDOWS) + LW'(k_q);
  assign rd_addr  = rd_lin[AW-1:0];

  always_comb begin
    vi_d       = vi_q;
    k_d        = k_q;
    rd_en      = 1'b0;
    next_valve = 1'b0;
    if (cmd_i.scan_start) begin
      vi_d = '0;
      k_d  = '0;
    end else if (cmd_i.scan_step) begin
      if (active) begin
        rd_en = 1'b1;
        if (CW'(k_q) + CW'(1) == cur_cnt) begin
          next_valve = 1'b1;
        end else begin
          k_d = k_q + KW'(1);
        end
      end else begin
        next_valve = 1'b1;
      end
      if (next_valve) begin
        k_d = '0;
        if (vi_q != VIW'(VALVE_COUNT - 1)) begin
          vi_d = vi_q + VIW'(1);
        end
      end
    end
  end

  assign status_o.scan_last = cmd_i.scan_step && next_valve &&
                              (vi_q == VIW'(VALVE_COUNT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vi_q <= '0;
      k_q  <= '0;
    end else begin
      vi_q <= vi_d;
      k_q  <= k_d;
    end
  end

  // Window table
  logic [wvsm_pkg::WIN_W-1:0] win_mem_q [DEPTH];
  logic [wvsm_pkg::WIN_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_win && win_ok) begin
      win_mem_q[wr_addr] <= {in_wday, in_ha, in_ma, in_hb, in_mb};
    end
    if (rd_en) begin
      rd_data_q <= win_mem_q[rd_addr];
    end
  end

  // Read tag follows the memory latency
  logic           rd_vld_q;
  logic [VIW-1:0] rd_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_tag_q <= vi_q;
    end
  end

  // Window match: own day, start inclusive, stop exclusive
  logic [wvsm_pkg::WDAY_W-1:0] w_day;
  logic [wvsm_pkg::HOUR_W-1:0] w_sh, w_eh;
  logic [wvsm_pkg::MIN_W-1:0]  w_sm, w_em;
  logic                        win_hit;

  assign w_day = rd_data_q[wvsm_pkg::WOFF_DAY +: wvsm_pkg::WDAY_W];
  assign w_sh  = rd_data_q[wvsm_pkg::WOFF_SH  +: wvsm_pkg::HOUR_W];
  assign w_sm  = rd_data_q[wvsm_pkg::WOFF_SM  +: wvsm_pkg::MIN_W];
  assign w_eh  = rd_data_q[wvsm_pkg::WOFF_EH  +: wvsm_pkg::HOUR_W];
  assign w_em  = rd_data_q[wvsm_pkg::WOFF_EM  +: wvsm_pkg::MIN_W];

  assign win_hit = rd_vld_q && (w_day == dow_q) && (hr_q >= w_sh) && (hr_q <= w_eh) &&
                   !((hr_q == w_sh) && (mn_q < w_sm)) &&
                   !((hr_q == w_eh) && (mn_q >= w_em));

  // Per-valve hit flags
  logic [wvsm_pkg::PATTERN_W-1:0] hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= '0;
    end else if (cmd_i.scan_start) begin
      hit_q <= '0;
    end else if (win_hit) begin
      hit_q[rd_tag_q] <= 1'b1;
    end
  end

  // Output levels
  logic [wvsm_pkg::PATTERN_W-1:0] pattern;

  always_comb begin
    logic [1:0] md;
    logic       open;
    pattern = '0;
    for (int i = 0; i < wvsm_pkg::PATTERN_W; i++) begin
      md   = modes_q[2*i +: 2];
      open = (md == wvsm_pkg::MODE_ON) || ((md == wvsm_pkg::MODE_SCHED) && hit_q[i]);
      if (i < VALVE_COUNT) begin
        pattern[i] = open ? pol_q[i] : !pol_q[i];
      end
    end
  end

  // Result register
  logic [wvsm_pkg::OUT_TDATA_W-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_out) begin
      out_q <= {5'b0, dow_q, pattern};
    end
  end

  assign m_tdata_o = out_q;

endmodule

`default_nettype wire

// File: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wvsm_pkg::*;

  localparam int VALVES      = 16;
  localparam int SLOTS       = 8;
  localparam int SETTLE      = 150;        // a little over the longest tick scan
  localparam int CYCLE_LIMIT = 1_200_000;
  localparam logic [1:0] REQ_RESERVED   = 2'd3;
  localparam logic [1:0] MODE_THREE_OFF = 2'd3;

  // One request body as it sits on s_tdata, lowest field last
  typedef struct packed {
    bit [1:0]  fill;
    bit [11:0] year;
    bit [3:0]  month;
    bit [4:0]  dday;
    bit [5:0]  mb;
    bit [4:0]  hb;
    bit [5:0]  ma;
    bit [4:0]  ha;
    bit [2:0]  wday;
    bit [3:0]  slot;
    bit [3:0]  valve;
  } request_t;

  // One stored window
  typedef struct packed {
    bit [2:0] day;
    bit [4:0] sh;
    bit [5:0] sm;
    bit [4:0] eh;
    bit [5:0] em;
  } window_t;

  // Mirror of the window table and registers; predicts the valve pattern
  // of each tick and checks it against what comes out
  class schedule_tracker;
    window_t   win_tab [VALVES*SLOTS];
    bit        written [VALVES*SLOTS];
    bit [3:0]  win_cnt [VALVES];
    bit [15:0] polarity = 16'hFFFF;
    bit [31:0] modes = '0;
    bit [18:0] pending_patterns [$];   // {day of week, valve pattern}
    int n_writes, n_counts, n_ticks, n_ignored, n_checked, n_opened, errors;

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == CFG_POLARITY) polarity = val[15:0];
      else modes = val;
    endfunction

    // Day of week with truncating division, remainder folded into 0..6
    function int weekday(int day, int month, int year);
      int d, y, r;
      d = day;
      y = year;
      if (month < 3) begin
        d += y;
        y -= 1;
      end else begin
        d += y - 2;
      end
      r = (23 * month / 9 + d + 4 + y / 4 - y / 100 + y / 400) % 7;
      if (r < 0) r += 7;
      return r;
    endfunction

    // Start inclusive, stop exclusive, own day only
    function bit covers(window_t w, int dow, int hr, int mn);
      if (dow != w.day) return 1'b0;
      if (hr < w.sh || hr > w.eh) return 1'b0;
      if (hr == w.sh && mn < w.sm) return 1'b0;
      if (hr == w.eh && mn >= w.em) return 1'b0;
      return 1'b1;
    endfunction

    function void take_request(logic [1:0] kind, request_t rq);
      int idx, dow, i, k;
      bit is_open;
      bit [1:0] md;
      bit [15:0] pattern;
      case (kind)
        REQ_WRITE: begin
          if (rq.slot < SLOTS && rq.wday <= 6 && rq.ha <= 23 && rq.ma <= 59 &&
              rq.hb <= 23 && rq.mb <= 59) begin
            idx = rq.valve * SLOTS + rq.slot;
            win_tab[idx] = {rq.wday, rq.ha, rq.ma, rq.hb, rq.mb};
            written[idx] = 1'b1;
            n_writes++;
          end else begin
            n_ignored++;
          end
        end
        REQ_COUNT: begin
          if (rq.slot <= SLOTS) begin
            win_cnt[rq.valve] = rq.slot;
            n_counts++;
          end else begin
            n_ignored++;
          end
        end
        REQ_TICK: begin
          dow = weekday(rq.dday, rq.month, rq.year);
          for (i = 0; i < VALVES; i++) begin
            md = modes[2*i +: 2];
            is_open = 1'b0;
            if (md == MODE_ON) begin
              is_open = 1'b1;
            end else if (md == MODE_SCHED) begin
              for (k = 0; k < win_cnt[i] && !is_open; k++)
                is_open = covers(win_tab[i*SLOTS + k], dow, rq.ha, rq.ma);
              if (is_open) n_opened++;
            end
            pattern[i] = is_open ? polarity[i] : !polarity[i];
          end
          pending_patterns.push_back({3'(dow), pattern});
          n_ticks++;
        end
        default: n_ignored++;
      endcase
    endfunction

    function void check_pattern(logic [23:0] data);
      bit [18:0] want;
      n_checked++;
      if (pending_patterns.size() == 0) begin
        errors++;
        if (errors <= 10) $display("pattern %h arrived with no tick pending", data);
        return;
      end
      want = pending_patterns.pop_front();
      if (data[15:0] !== want[15:0] || data[18:16] !== want[18:16] || data[23:19] !== '0)
      begin
        errors++;
        if (errors <= 10)
          $display("pattern %0d: expected valves %h day %0d, got valves %h day %0d fill %h",
                   n_checked, want[15:0], want[18:16], data[15:0], data[18:16], data[23:19]);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [1:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_index_i = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata_i = '0;

  schedule_tracker tracker = new;
  bit              calm = 1'b0;      // no idling on either side while set
  int              stall_left = 0;
  int unsigned     cycles = 0;

  weekly_valve_schedule_matcher_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d ticks still pending", cycles,
               tracker.pending_patterns.size());
      $display("weekly_valve_schedule_matcher_core: mismatch");
      $finish;
    end
  end

  // Result side: random short stalls
  always @(negedge clk_i) begin
    if (stall_left == 0 && !calm && $urandom_range(99) < 3) stall_left = $urandom_range(1, 5);
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) tracker.check_pattern(m_tdata);
  end

  // Random fill so unused fields toggle too
  function automatic request_t noise_fields();
    bit [63:0] raw;
    request_t rq;
    raw = {$urandom, $urandom};
    rq = raw[55:0];
    rq.fill = '0;
    return rq;
  endfunction

  function automatic request_t win_req(int v, int s, int wd, int sh, int sm, int eh, int em);
    request_t rq;
    rq = noise_fields();
    rq.valve = 4'(v);
    rq.slot  = 4'(s);
    rq.wday  = 3'(wd);
    rq.ha    = 5'(sh);
    rq.ma    = 6'(sm);
    rq.hb    = 5'(eh);
    rq.mb    = 6'(em);
    return rq;
  endfunction

  function automatic request_t cnt_req(int v, int c);
    request_t rq;
    rq = noise_fields();
    rq.valve = 4'(v);
    rq.slot  = 4'(c);
    return rq;
  endfunction

  function automatic request_t tick_req(int y, int mo, int d, int h, int mi);
    request_t rq;
    rq = noise_fields();
    rq.year  = 12'(y);
    rq.month = 4'(mo);
    rq.dday  = 5'(d);
    rq.ha    = 5'(h);
    rq.ma    = 6'(mi);
    return rq;
  endfunction

  // Random request mix: mostly valid windows, counts and ticks aimed at
  // stored windows; some malformed and reserved requests as noise
  function automatic void make_request(output logic [1:0] kind, output request_t rq,
                                       output bit skip);
    int r, v, c, st, en, t, wd, base, k, tries;
    window_t w;
    r = $urandom_range(99);
    v = $urandom_range(15);
    skip = 1'b0;
    if (r < 36 || (r >= 46 && r < 50)) begin
      kind = REQ_WRITE;
      case ($urandom_range(9))
        0: st = 0;
        1: st = 1439;
        default: st = $urandom_range(1439);
      endcase
      case ($urandom_range(9))
        0: en = $urandom_range(1439);
        1: en = st;
        default: en = st + int'($urandom_range(1, 240));
      endcase
      if (en > 1439) en = 1439;
      rq = win_req(v, $urandom_range(7), $urandom_range(6), st / 60, st % 60, en / 60, en % 60);
      if (r >= 46) begin
        skip = 1'b1;
        case ($urandom_range(5))
          0: rq.slot = 4'($urandom_range(8, 15));
          1: rq.wday = 3'd7;
          2: rq.ha = 5'($urandom_range(24, 31));
          3: rq.ma = 6'($urandom_range(60, 63));
          4: rq.hb = 5'($urandom_range(24, 31));
          default: rq.mb = 6'($urandom_range(60, 63));
        endcase
      end
    end else if (r < 46) begin
      // count only as far as the slots already written
      kind = REQ_COUNT;
      c = $urandom_range(8);
      k = 0;
      while (k < c && tracker.written[v*SLOTS + k]) k++;
      rq = cnt_req(v, k);
    end else if (r < 53) begin
      kind = REQ_COUNT;
      rq = cnt_req(v, $urandom_range(9, 15));
      skip = 1'b1;
    end else if (r < 55) begin
      kind = REQ_RESERVED;
      rq = noise_fields();
      skip = 1'b1;
    end else if (r < 62) begin
      // tick with date and time at full field width
      kind = REQ_TICK;
      rq = noise_fields();
    end else begin
      kind = REQ_TICK;
      rq = tick_req($urandom_range(1970, 2199), $urandom_range(1, 12), $urandom_range(1, 31),
                    $urandom_range(23), $urandom_range(59));
      if (r < 80) begin
        // land on, next to or inside a window in use
        tries = 0;
        while (tries < 16 && tracker.win_cnt[v] == 0) begin
          v = $urandom_range(15);
          tries++;
        end
        if (tracker.win_cnt[v] != 0) begin
          w = tracker.win_tab[v*SLOTS + int'($urandom_range(tracker.win_cnt[v] - 1))];
          base = tracker.weekday(1, rq.month, rq.year);
          wd = w.day;
          k = (wd - base + 7) % 7;
          rq.dday = 5'(1 + k + 7 * int'($urandom_range(3)));
          st = w.sh * 60 + w.sm;
          en = w.eh * 60 + w.em;
          case ($urandom_range(4))
            0: t = st;
            1: t = st - 1;
            2: t = en;
            3: t = en - 1;
            default: t = (en > st) ? st + int'($urandom_range(en - st - 1)) : st;
          endcase
          if (t < 0) t = 0;
          if (t > 1439) t = 1439;
          rq.ha = 5'(t / 60);
          rq.ma = 6'(t % 60);
        end
      end
    end
  endfunction

  // Called and returning at a falling edge
  task automatic send_request(input logic [1:0] kind, input request_t body);
    if (!calm && $urandom_range(99) < 3) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= body;
    do @(posedge clk_i); while (!s_tready);
    tracker.take_request(kind, body);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    tracker.set_reg(idx, val);
  endtask

  // Drain all ticks, then give trailing writes time to land
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (tracker.pending_patterns.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  initial begin
    int p, n, useful, i;
    logic [15:0] pol;
    logic [31:0] md;
    logic [1:0] kind;
    request_t rq;
    bit skip;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: valves 12..15 forced off, forced on, scheduled, mode three
    write_reg(CFG_POLARITY, 32'h0000_A5A5);
    write_reg(CFG_MODES, 32'hE4AA_AAAA);
    send_request(REQ_WRITE, win_req(0, 0, 0, 0, 0, 23, 59));
    send_request(REQ_WRITE, win_req(1, 0, 3, 10, 30, 10, 45));
    send_request(REQ_WRITE, win_req(2, 0, 3, 12, 0, 11, 0));   // stop before start
    send_request(REQ_WRITE, win_req(3, 0, 3, 10, 0, 11, 0));
    send_request(REQ_WRITE, win_req(15, 0, 6, 23, 58, 23, 59));
    // malformed writes must leave valve 3 slot 0 alone
    send_request(REQ_WRITE, win_req(3, 8, 3, 1, 0, 2, 0));
    send_request(REQ_WRITE, win_req(3, 0, 7, 10, 0, 11, 0));
    send_request(REQ_WRITE, win_req(3, 0, 3, 24, 0, 11, 0));
    send_request(REQ_WRITE, win_req(3, 0, 3, 9, 0, 10, 60));
    send_request(REQ_COUNT, cnt_req(0, 1));
    send_request(REQ_COUNT, cnt_req(1, 1));
    send_request(REQ_COUNT, cnt_req(2, 1));
    send_request(REQ_COUNT, cnt_req(3, 1));
    send_request(REQ_COUNT, cnt_req(15, 1));
    send_request(REQ_COUNT, cnt_req(0, 9));                   // too many, ignored
    send_request(REQ_TICK, tick_req(2024, 1, 3, 10, 30));
    send_request(REQ_TICK, tick_req(2024, 1, 3, 10, 45));
    send_request(REQ_TICK, tick_req(2023, 1, 1, 0, 0));
    send_request(REQ_TICK, tick_req(2024, 1, 6, 23, 58));
    send_request(REQ_RESERVED, noise_fields());
    send_request(REQ_COUNT, cnt_req(0, 0));                   // clears valve 0
    send_request(REQ_TICK, tick_req(2023, 1, 1, 0, 0));
    send_request(REQ_TICK, tick_req(0, 1, 0, 31, 63));
    send_request(REQ_TICK, tick_req(4095, 15, 31, 0, 0));
    send_request(REQ_TICK, tick_req(0, 0, 31, 12, 0));
    send_request(REQ_TICK, tick_req(2199, 12, 31, 23, 59));

    // Random phases, one register setting each
    for (p = 1; p <= 7; p++) begin
      wait_idle();
      n = 350;
      case (p)
        1: begin
          pol = 16'hFFFF;
          md  = 32'hAAAA_AAAA;
        end
        2: begin
          pol = 16'h0000;
          md  = 32'hAAAA_AAAA;
        end
        3: begin
          pol = 16'hFFFF;
          md  = 32'h0000_0000;
          n   = 120;
        end
        4: begin
          pol = 16'h0000;
          md  = 32'hFFFF_FFFF;
          n   = 120;
        end
        5: begin
          pol = 16'($urandom);
          md  = $urandom;
        end
        6: begin
          pol = 16'($urandom);
          for (i = 0; i < VALVES; i++) begin
            case ($urandom_range(9))
              0: md[2*i +: 2] = MODE_OFF;
              1: md[2*i +: 2] = MODE_ON;
              2: md[2*i +: 2] = MODE_THREE_OFF;
              default: md[2*i +: 2] = MODE_SCHED;
            endcase
          end
        end
        default: begin
          pol = 16'hFFFF;
          md  = 32'h5555_5555;
          n   = 120;
        end
      endcase
      calm = (p == 2);
      write_reg(CFG_POLARITY, {16'h0000, pol});
      write_reg(CFG_MODES, md);
      useful = 0;
      while (useful < n) begin
        make_request(kind, rq, skip);
        send_request(kind, rq);
        if (!skip) useful++;
      end
    end
    calm = 1'b0;
    wait_idle();

    $display("sent %0d window writes, %0d counts, %0d ticks and %0d ignored requests",
             tracker.n_writes, tracker.n_counts, tracker.n_ticks, tracker.n_ignored);
    $display("8 register settings, %0d patterns checked, %0d valve-ticks opened by windows",
             tracker.n_checked, tracker.n_opened);
    if (tracker.errors == 0 && tracker.pending_patterns.size() == 0) begin
      $display("weekly_valve_schedule_matcher_core: match");
    end else begin
      $display("%0d mismatches, %0d ticks without a pattern", tracker.errors,
               tracker.pending_patterns.size());
      $display("weekly_valve_schedule_matcher_core: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/wvsm_pkg.sv
hw/rtl/wvsm_ctrl.sv
hw/rtl/wvsm_datapath.sv
hw/rtl/weekly_valve_schedule_matcher_core.sv
test/tb_top.sv
